[hdl/puh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package puh_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] HASH_SEED  = 32'hFFFF_FFFF;
   localparam logic [31:0] MIX_C1     = 32'hCC9E_2D51;
   localparam logic [31:0] MIX_C2     = 32'h1B87_3593;
   localparam logic [31:0] MIX_ADD    = 32'hE654_6B64;
   localparam logic [31:0] FMIX_C1    = 32'h85EB_CA6B;
   localparam logic [31:0] FMIX_C2    = 32'hC2B2_AE35;
   localparam logic [31:0] UNIT_BYTES = 32'd2;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET    = 8'h20;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CASE_CHANGE_ENABLE = 2'd0,
      CSR_CASE_TO_LOWER      = 2'd1,
      CSR_HASH_TERMINATOR    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic case_change_enable;
      logic case_to_lower;
      logic hash_terminator;
   } cfg_type;

   typedef struct packed {
      logic       is_term;
      logic [7:0] unit_char;
   } entry_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

endpackage

`default_nettype wire

[hdl/puh_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface puh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_byte;

   modport source (output valid, output path_byte, input ready);
   modport sink   (input valid, input path_byte, output ready);
endinterface

interface puh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

[hdl/puh_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module puh_front
   import puh_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   puh_req_if.sink                req_port,
   input  wire                    csr_write_enable,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_write_data,
   output cfg_type                cfg,
   output logic                   push_valid,
   input  wire                    push_ready,
   output entry_type              push_data
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [7:0] slash_char;
   logic [7:0] norm_char;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CASE_CHANGE_ENABLE: cfg_in.case_change_enable = csr_write_data[0];
            CSR_CASE_TO_LOWER:      cfg_in.case_to_lower      = csr_write_data[0];
            CSR_HASH_TERMINATOR:    cfg_in.hash_terminator    = csr_write_data[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{case_change_enable: 1'b1, case_to_lower: 1'b1, hash_terminator: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // fold backslash to slash, then apply the case mapping
   always_comb begin
      slash_char = (req_port.path_byte == CHAR_BACKSLASH) ? CHAR_SLASH : req_port.path_byte;
      norm_char  = slash_char;
      if (cfg_ff.case_change_enable) begin
         if (cfg_ff.case_to_lower) begin
            if (slash_char >= CHAR_UPPER_A && slash_char <= CHAR_UPPER_Z) begin
               norm_char = slash_char + CASE_OFFSET;
            end
         end else begin
            if (slash_char >= CHAR_LOWER_A && slash_char <= CHAR_LOWER_Z) begin
               norm_char = slash_char - CASE_OFFSET;
            end
         end
      end
   end

   assign push_valid          = req_port.valid;
   assign req_port.ready      = push_ready;
   assign push_data.is_term   = (req_port.path_byte == CHAR_NUL);
   assign push_data.unit_char = norm_char;
   assign cfg                 = cfg_ff;

endmodule

`default_nettype wire

[hdl/puh_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module puh_queue
   import puh_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        push_valid,
   output logic       push_ready,
   input  entry_type  push_data,
   output logic       pop_valid,
   input  wire        pop_ready,
   output entry_type  pop_data
);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/puh_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module puh_back
   import puh_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  cfg_type    cfg,
   input  wire        pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_data,
   puh_rsp_if.source  rsp_port
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b000_0001,
      ST_SC1  = 7'b000_0010,
      ST_SC2  = 7'b000_0100,
      ST_SC3  = 7'b000_1000,
      ST_FIN0 = 7'b001_0000,
      ST_FIN1 = 7'b010_0000,
      ST_FIN2 = 7'b100_0000
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic [7:0]  held_ff;
   logic [7:0]  held_in;
   logic        half_ff;
   logic        half_in;
   logic [31:0] total_ff;
   logic [31:0] total_in;
   logic [31:0] op_ff;
   logic [31:0] op_in;
   logic        mix_mode_ff;
   logic        mix_mode_in;
   logic        term_ff;
   logic        term_in;
   logic        out_vld_ff;
   logic        out_vld_in;
   logic [31:0] out_ff;
   logic [31:0] out_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] mul_p;
   logic [31:0] fin_x;
   logic [31:0] mix_r;
   logic        out_free;

   assign mul_p    = mul_a * mul_b;
   assign fin_x    = acc_ff ^ total_ff;
   assign mix_r    = rotl(acc_ff ^ op_ff, 13);
   assign out_free = !out_vld_ff || rsp_port.ready;

   // one shared multiplier, operands chosen by step
   always_comb begin
      mul_a = op_ff;
      mul_b = MIX_C1;
      unique case (state_ff)
         ST_SC1:  begin mul_a = op_ff;                     mul_b = MIX_C1;  end
         ST_SC2:  begin mul_a = rotl(op_ff, 15);           mul_b = MIX_C2;  end
         ST_FIN0: begin mul_a = fin_x ^ (fin_x >> 16);     mul_b = FMIX_C1; end
         ST_FIN1: begin mul_a = op_ff ^ (op_ff >> 13);     mul_b = FMIX_C2; end
         default: begin mul_a = op_ff;                     mul_b = MIX_C1;  end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      held_in     = held_ff;
      half_in     = half_ff;
      total_in    = total_ff;
      op_in       = op_ff;
      mix_mode_in = mix_mode_ff;
      term_in     = term_ff;
      out_vld_in  = out_vld_ff && !rsp_port.ready;
      out_in      = out_ff;
      pop_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               term_in = pop_data.is_term;
               if (!pop_data.is_term) begin
                  total_in = total_ff + UNIT_BYTES;
                  if (!half_ff) begin
                     held_in = pop_data.unit_char;
                     half_in = 1'b1;
                  end else begin
                     op_in       = {8'h00, pop_data.unit_char, 8'h00, held_ff};
                     mix_mode_in = 1'b1;
                     held_in     = '0;
                     half_in     = 1'b0;
                     state_in    = ST_SC1;
                  end
               end else begin
                  if (cfg.hash_terminator) begin
                     total_in = total_ff + UNIT_BYTES;
                  end
                  op_in       = {24'h00_0000, held_ff};
                  mix_mode_in = cfg.hash_terminator;
                  state_in    = half_ff ? ST_SC1 : ST_FIN0;
               end
            end
         end
         ST_SC1: begin
            op_in    = mul_p;
            state_in = ST_SC2;
         end
         ST_SC2: begin
            op_in    = mul_p;
            state_in = ST_SC3;
         end
         ST_SC3: begin
            if (mix_mode_ff) begin
               acc_in = (mix_r << 2) + mix_r + MIX_ADD;
            end else begin
               acc_in = acc_ff ^ op_ff;
            end
            state_in = term_ff ? ST_FIN0 : ST_IDLE;
         end
         ST_FIN0: begin
            op_in    = mul_p;
            state_in = ST_FIN1;
         end
         ST_FIN1: begin
            op_in    = mul_p;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            if (out_free) begin
               out_in     = op_ff ^ (op_ff >> 16);
               out_vld_in = 1'b1;
               acc_in     = HASH_SEED;
               held_in    = '0;
               half_in    = 1'b0;
               total_in   = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_ff     <= HASH_SEED;
         held_ff    <= '0;
         half_ff    <= 1'b0;
         total_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         half_ff    <= half_in;
         total_ff   <= total_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      mix_mode_ff <= mix_mode_in;
      term_ff     <= term_in;
      out_ff      <= out_in;
   end

   assign rsp_port.valid      = out_vld_ff;
   assign rsp_port.hash_value = out_ff;

endmodule

`default_nettype wire

[hdl/path_utf16_murmur3_hash.sv]
`timescale 1ns / 1ps
`default_nettype none

// Path hash: takes a file path one byte per transfer on req_port, a zero byte
// closing the path, and returns one transfer on rsp_port carrying the 32-bit
// MurmurHash3 x86_32 (seed 0xFFFFFFFF) of the path widened to UTF-16LE, after
// backslashes are folded to slashes and, if enabled, letter case is mapped.
// The hash is returned only on the terminator; every other byte gives no
// result, and the next byte after a terminator starts a fresh path.
// Steps: the first byte of each character pair is only held; the second
// runs the block mix, three steps through a single shared 32x32 multiplier,
// and no byte is taken until it is done; the terminator runs the tail mix
// if a byte is held, then the two multiply steps of the finaliser and a last
// step that waits on rsp_port. A two-entry queue between the byte front end
// and the hash engine absorbs short bursts, and a registered result lets the
// engine move on while an earlier hash waits to be taken.
// Registers (csr_index): 0 case change enable (reset 1), 1 lower case when 1,
// upper case when 0 (reset 1), 2 include the terminator unit in the hash
// (reset 0). Only bit 0 of csr_write_data is used; other indices are ignored.
// Write registers only while the block is idle.

module path_utf16_murmur3_hash
   import puh_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   puh_req_if.sink                req_port,
   puh_rsp_if.source              rsp_port,
   input  wire                    csr_write_enable,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_write_data
);

   cfg_type   cfg;
   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_data;

   // classify and normalise each byte, hold the configuration
   puh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_port),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // decouple the byte front end from the multiply engine
   puh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // block mixing, tail, length and finaliser; drive the result register
   puh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_port  (rsp_port)
   );

endmodule

`default_nettype wire
